### hw/rtl/wave1d_pkg.sv
// Shared types, codes and constants of the 1D leapfrog wave stencil.
// Depends on nothing; every other file but wave1d_ram imports it.
package wave1d_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int FRAME_COUNT    = 3;
   localparam int CMD_Q_DEPTH    = 2;

   localparam int MODE_W    = 2;
   localparam int INDEX_W   = 10;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int TAU_W     = 17;
   localparam int NPTS_W    = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;
   localparam int SLOT_W    = 2;

   localparam logic [TAU_W-1:0]  TAU_ONE   = 17'd65536;
   localparam logic [TAU_W-1:0]  TAU_RST   = 17'd16384;
   localparam logic [NPTS_W-1:0] NPTS_RST  = 11'd1024;
   localparam logic [NPTS_W-1:0] NPTS_MIN  = 11'd3;

   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TAU  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NPTS = 2'd1;

   localparam logic [SLOT_W-1:0] SLOT_0 = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_1 = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_2 = 2'd2;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_ADVANCE,
      OP_READ,
      OP_NOP,
      OP_RANGE_ERR
   } op_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] point_value;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   typedef struct packed {
      op_type                    op;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

### hw/rtl/wave1d_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module wave1d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

### hw/rtl/wave1d_fifo.sv
// Short command queue between the front and the back.
// Depends on wave1d_pkg (cmd_type, CMD_Q_DEPTH).
module wave1d_fifo
   import wave1d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_data
);

   localparam int PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);

   cmd_type           slot_ff [CMD_Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(CMD_Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(CMD_Q_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### hw/rtl/wave1d_front.sv
// Front end: configuration registers, point-count clamp and command classification.
// Depends on wave1d_pkg (req_type, cmd_type, mode and register codes).
module wave1d_front
   import wave1d_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [CSR_DAT_W-1:0]                 csr_wdata,
   input  req_type                              req_data,
   output cmd_type                              cmd,
   output logic [$clog2(MAX_POINTS+1)-1:0]      eff_points,
   output logic [TAU_W-1:0]                     eff_tau
);

   localparam int PW = $clog2(MAX_POINTS + 1);

   logic [TAU_W-1:0]  tau_ff;
   logic [NPTS_W-1:0] npts_ff;
   logic [PW-1:0]     n_val;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff  <= TAU_RST;
         npts_ff <= NPTS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TAU:  tau_ff  <= csr_wdata[TAU_W-1:0];
            CSR_NPTS: npts_ff <= csr_wdata[NPTS_W-1:0];
            default:  ;
         endcase
      end
   end

   // Clamp the point count to [3, MAX_POINTS] and tau to 1.0.
   always_comb begin
      if (npts_ff < NPTS_MIN) begin
         n_val = PW'(NPTS_MIN);
      end else if (32'(npts_ff) > 32'(MAX_POINTS)) begin
         n_val = PW'(MAX_POINTS);
      end else begin
         n_val = PW'(npts_ff);
      end
   end

   assign eff_points = n_val;
   assign eff_tau    = (tau_ff > TAU_ONE) ? TAU_ONE : tau_ff;

   always_comb begin
      cmd.index = req_data.index;
      cmd.value = req_data.value;
      case (req_data.mode)
         MODE_LOAD:    cmd.op = (32'(req_data.index) >= 32'(n_val)) ? OP_RANGE_ERR : OP_LOAD;
         MODE_ADVANCE: cmd.op = OP_ADVANCE;
         MODE_READ:    cmd.op = (32'(req_data.index) >= 32'(n_val)) ? OP_RANGE_ERR : OP_READ;
         default:      cmd.op = OP_NOP;
      endcase
   end

endmodule

### hw/rtl/wave1d_back.sv
// Back end: frame ring in three RAMs, load/read execution and the advance sweep pipeline.
// Depends on wave1d_pkg and wave1d_ram.
module wave1d_back
   import wave1d_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  cmd_type                         cmd,
   input  logic [$clog2(MAX_POINTS+1)-1:0] eff_points,
   input  logic [TAU_W-1:0]                eff_tau,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rsp_type                         rsp_data
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PW = $clog2(MAX_POINTS + 1);

   localparam logic signed [52:0] RND_HALF = 53'sd32768;
   localparam logic signed [37:0] SAT_MAX  = 38'sd2147483647;
   localparam logic signed [37:0] SAT_MIN  = -38'sd2147483648;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SWEEP
   } state_type;

   state_type         state_ff;
   logic [SLOT_W-1:0] cur_ff;
   logic [SLOT_W-1:0] prev_slot, next_slot;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              sat_ff;

   // sweep pipeline: issue, RAM data, laplacian, product
   logic              iss_on_ff;
   logic [PW-1:0]     iss_pos_ff;
   logic              vb_ff, vc_ff, vd_ff;
   logic [PW-1:0]     pb_ff, ic_ff, id_ff;
   logic signed [VALUE_W-1:0] wa_ff, wb_ff;
   logic signed [34:0] lap_ff, lap_in;
   logic signed [33:0] basec_ff, basec_in, based_ff;
   logic signed [52:0] prod_ff, prod_in;

   logic signed [VALUE_W-1:0] u_w, l_w, r_w, cur_rd, prev_rd;
   logic signed [52:0] pr_w;
   logic signed [36:0] rnd_w;
   logic signed [37:0] sum_w;
   logic signed [VALUE_W-1:0] new_val;
   logic               sat_now, last_pt;

   logic              pop;
   logic [AW-1:0]     idx_addr, cur_raddr, prev_raddr, sweep_waddr;
   logic [PW-1:0]     pos_m1;

   logic              ram_we    [FRAME_COUNT];
   logic [AW-1:0]     ram_waddr [FRAME_COUNT];
   logic [VALUE_W-1:0] ram_wdata [FRAME_COUNT];
   logic [AW-1:0]     ram_raddr [FRAME_COUNT];
   logic [VALUE_W-1:0] ram_rdata [FRAME_COUNT];

   assign pop       = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (cur_ff)
         SLOT_0:  begin prev_slot = SLOT_2; next_slot = SLOT_1; end
         SLOT_1:  begin prev_slot = SLOT_0; next_slot = SLOT_2; end
         default: begin prev_slot = SLOT_1; next_slot = SLOT_0; end
      endcase
   end

   assign idx_addr    = AW'(cmd.index);
   assign pos_m1      = iss_pos_ff - 1'b1;
   assign cur_raddr   = iss_on_ff ? iss_pos_ff[AW-1:0] : idx_addr;
   assign prev_raddr  = pos_m1[AW-1:0];
   assign sweep_waddr = id_ff[AW-1:0];

   // Map roles onto the three slot RAMs.
   for (genvar s = 0; s < FRAME_COUNT; s++) begin : g_slot
      logic is_cur, is_prev, is_next, do_load;
      assign is_cur  = (cur_ff == SLOT_W'(s));
      assign is_prev = (prev_slot == SLOT_W'(s));
      assign is_next = (next_slot == SLOT_W'(s));
      assign do_load = pop && (cmd.op == OP_LOAD);

      assign ram_we[s]    = (do_load && (is_cur || is_prev)) || (vd_ff && is_next);
      assign ram_waddr[s] = do_load ? idx_addr : sweep_waddr;
      assign ram_wdata[s] = do_load ? cmd.value : new_val;
      assign ram_raddr[s] = is_cur ? cur_raddr : prev_raddr;

      wave1d_ram #(
         .WIDTH (VALUE_W),
         .DEPTH (MAX_POINTS)
      ) u_ram (
         .clock (clock),
         .we    (ram_we[s]),
         .waddr (ram_waddr[s]),
         .wdata (ram_wdata[s]),
         .raddr (ram_raddr[s]),
         .rdata (ram_rdata[s])
      );
   end

   always_comb begin
      case (cur_ff)
         SLOT_0:  begin cur_rd = ram_rdata[0]; prev_rd = ram_rdata[2]; end
         SLOT_1:  begin cur_rd = ram_rdata[1]; prev_rd = ram_rdata[0]; end
         default: begin cur_rd = ram_rdata[2]; prev_rd = ram_rdata[1]; end
      endcase
   end

   // Point pb-1 sees its left, center and right; mirror the missing neighbor at each end.
   assign u_w = wa_ff;
   assign l_w = (pb_ff == PW'(1)) ? cur_rd : wb_ff;
   assign r_w = (pb_ff == eff_points) ? wb_ff : cur_rd;

   assign lap_in   = 35'(l_w) + 35'(r_w) - (35'(u_w) <<< 1);
   assign basec_in = (34'(u_w) <<< 1) - 34'(prev_rd);
   assign prod_in  = 53'($signed({1'b0, eff_tau})) * 53'(lap_ff);

   // Round to nearest, ties up, then add 2u - uold and saturate.
   assign pr_w  = prod_ff + RND_HALF;
   assign rnd_w = 37'(pr_w >>> 16);
   assign sum_w = 38'(based_ff) + 38'(rnd_w);

   always_comb begin
      sat_now = 1'b0;
      new_val = VALUE_W'(sum_w);
      if (sum_w > SAT_MAX) begin
         sat_now = 1'b1;
         new_val = VALUE_W'(SAT_MAX);
      end else if (sum_w < SAT_MIN) begin
         sat_now = 1'b1;
         new_val = VALUE_W'(SAT_MIN);
      end
   end

   assign last_pt = vd_ff && (id_ff == eff_points - 1'b1);

   // Datapath registers of the sweep.
   always_ff @(posedge clock) begin
      pb_ff <= iss_pos_ff;
      if (vb_ff) begin
         wa_ff <= cur_rd;
         wb_ff <= wa_ff;
      end
      lap_ff   <= lap_in;
      basec_ff <= basec_in;
      ic_ff    <= pb_ff - 1'b1;
      prod_ff  <= prod_in;
      based_ff <= basec_ff;
      id_ff    <= ic_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= SLOT_0;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
         iss_on_ff    <= 1'b0;
         iss_pos_ff   <= '0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         vb_ff <= iss_on_ff;
         vc_ff <= vb_ff && (pb_ff != '0);
         vd_ff <= vc_ff;

         if (iss_on_ff) begin
            iss_pos_ff <= iss_pos_ff + 1'b1;
            if (iss_pos_ff == eff_points) begin
               iss_on_ff <= 1'b0;
            end
         end

         if (vd_ff && sat_now) begin
            sat_ff <= 1'b1;
         end

         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  rsp_ff.point_value <= '0;
                  rsp_ff.status      <= ST_OK;
                  case (cmd.op)
                     OP_ADVANCE: begin
                        state_ff   <= S_SWEEP;
                        iss_on_ff  <= 1'b1;
                        iss_pos_ff <= '0;
                        sat_ff     <= 1'b0;
                     end
                     OP_READ: begin
                        state_ff <= S_READ;
                     end
                     OP_RANGE_ERR: begin
                        rsp_ff.status <= ST_RANGE;
                        rsp_valid_ff  <= 1'b1;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_READ: begin
               rsp_ff.point_value <= cur_rd;
               rsp_ff.status      <= ST_OK;
               rsp_valid_ff       <= 1'b1;
               state_ff           <= S_IDLE;
            end
            S_SWEEP: begin
               if (last_pt) begin
                  rsp_ff.point_value <= '0;
                  rsp_ff.status      <= (sat_ff || sat_now) ? ST_SAT : ST_OK;
                  rsp_valid_ff       <= 1'b1;
                  cur_ff             <= next_slot;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/wave_1d_leapfrog_stencil.sv
// Top level of the 1D leapfrog wave-equation stencil: front, command queue and back.
// Depends on wave1d_pkg, wave1d_front, wave1d_fifo, wave1d_back (and wave1d_ram below it).
//
//   channel  direction  handshake              beat
//   req_     in         req_valid / req_ready  req_data  (mode, index, value)
//   rsp_     out        rsp_valid / rsp_ready  rsp_data  (point_value, status)
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Load, unused mode and out-of-range beats are answered straight from idle in the back, a read
// after a registered RAM read, an advance after the one-point-per-cycle sweep over the
// current-frame RAM read port plus a three-stage arithmetic pipeline.
// Reset clears control state only; the frame store holds garbage until loaded.
// The queue accepts up to two beats while the back is busy or a result waits on rsp_ready.
module wave_1d_leapfrog_stencil
   import wave1d_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int PW = $clog2(MAX_POINTS + 1);

   cmd_type          front_cmd;
   cmd_type          q_cmd;
   logic             q_valid;
   logic             q_ready;
   logic [PW-1:0]    eff_points;
   logic [TAU_W-1:0] eff_tau;

   // Classify each beat and hold the configuration.
   wave1d_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_data   (req_data),
      .cmd        (front_cmd),
      .eff_points (eff_points),
      .eff_tau    (eff_tau)
   );

   // Decouple accept from execute.
   wave1d_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (front_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_cmd)
   );

   // Execute against the frame ring and drive the result register.
   wave1d_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .eff_points (eff_points),
      .eff_tau    (eff_tau),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### dv/tb_wave_1d_leapfrog_stencil.sv
// Self-checking testbench for wave_1d_leapfrog_stencil: load, advance and read beats checked
// against a cycle-free predictor of the three-frame leapfrog solver held in a scoreboard class.
// Depends on wave1d_pkg and the wave_1d_leapfrog_stencil RTL.
module tb_wave_1d_leapfrog_stencil;
   timeunit 1ns;
   timeprecision 1ps;
   import wave1d_pkg::*;

   // Codes the package leaves unnamed: the spare mode and the two unmapped register slots.
   localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam longint SAT_HI        = 64'sd2147483647;
   localparam longint SAT_LO        = -SAT_HI - 1;
   localparam int     SETTLE_CYCLES = MAX_POINTS_DEF + 64;
   localparam int     MAX_GAP       = 20;
   localparam int     WIDE_MESH     = 160;
   localparam int     PHASE_ITEMS   = 48;

   // Predicts every result from the beats accepted so far, in acceptance order.
   class wave_scoreboard;
      logic signed [VALUE_W-1:0] frame_mem [FRAME_COUNT][MAX_POINTS_DEF];
      bit                        filled    [FRAME_COUNT][MAX_POINTS_DEF];
      int                        cur_slot;
      logic [TAU_W-1:0]          tau_sq;
      logic [NPTS_W-1:0]         npts;
      rsp_type                   pending_q[$];
      int                        mismatches;

      function new();
         cur_slot   = 0;
         tau_sq     = TAU_RST;
         npts       = NPTS_RST;
         mismatches = 0;
      endfunction

      function int points();
         if (npts < NPTS_MIN) return NPTS_MIN;
         if (npts > MAX_POINTS_DEF) return MAX_POINTS_DEF;
         return npts;
      endfunction

      function int prev_slot();
         return (cur_slot + FRAME_COUNT - 1) % FRAME_COUNT;
      endfunction

      function int next_slot();
         return (cur_slot + 1) % FRAME_COUNT;
      endfunction

      function void write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_TAU:  tau_sq = data[TAU_W-1:0];
            CSR_NPTS: npts   = data[NPTS_W-1:0];
            default: ;
         endcase
      endfunction

      // Both frames that an advance reads hold a written value at this point.
      function bit loaded(int idx);
         return filled[cur_slot][idx] && filled[prev_slot()][idx];
      endfunction

      function bit readable(int idx);
         return filled[cur_slot][idx];
      endfunction

      function bit ready_to_advance();
         for (int i = 0; i < points(); i++)
            if (!loaded(i)) return 1'b0;
         return 1'b1;
      endfunction

      // One leapfrog step over the whole mesh, mirrored ghosts at both ends.
      function logic [STATUS_W-1:0] step_frames();
         longint coef, here, old, left, right, lap, sum;
         int     n, nxt, prv, li, ri;
         bit     clipped;
         n       = points();
         nxt     = next_slot();
         prv     = prev_slot();
         coef    = (tau_sq > TAU_ONE) ? longint'(TAU_ONE) : longint'(tau_sq);
         clipped = 1'b0;
         for (int i = 0; i < n; i++) begin
            li    = (i == 0) ? 1 : i - 1;
            ri    = (i == n - 1) ? n - 2 : i + 1;
            here  = frame_mem[cur_slot][i];
            old   = frame_mem[prv][i];
            left  = frame_mem[cur_slot][li];
            right = frame_mem[cur_slot][ri];
            lap   = left - 2 * here + right;
            // round to nearest, ties toward plus infinity
            sum   = 2 * here - old + ((coef * lap + 32768) >>> 16);
            if (sum > SAT_HI) begin
               sum     = SAT_HI;
               clipped = 1'b1;
            end else if (sum < SAT_LO) begin
               sum     = SAT_LO;
               clipped = 1'b1;
            end
            frame_mem[nxt][i] = 32'(sum);
            filled[nxt][i]    = 1'b1;
         end
         cur_slot = nxt;
         return clipped ? ST_SAT : ST_OK;
      endfunction

      function void note(req_type beat);
         rsp_type want;
         int      n, idx;
         n    = points();
         idx  = beat.index;
         want = '0;
         case (beat.mode)
            MODE_LOAD: begin
               if (idx >= n) begin
                  want.status = ST_RANGE;
               end else begin
                  frame_mem[cur_slot][idx]    = beat.value;
                  frame_mem[prev_slot()][idx] = beat.value;
                  filled[cur_slot][idx]       = 1'b1;
                  filled[prev_slot()][idx]    = 1'b1;
               end
            end
            MODE_ADVANCE: want.status = step_frames();
            MODE_READ: begin
               if (idx >= n) want.status = ST_RANGE;
               else want.point_value = frame_mem[cur_slot][idx];
            end
            default: ;
         endcase
         pending_q.push_back(want);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 50) $display("[%0t] %s", $time, what);
      endtask

      task check(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result beat %h", got));
         end else begin
            want = pending_q.pop_front();
            if (got.point_value !== want.point_value)
               report($sformatf("point_value got %h, want %h",
                                got.point_value, want.point_value));
            if (got.status !== want.status)
               report($sformatf("status got %0d, want %0d", got.status, want.status));
         end
      endtask
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // Per-cycle odds (percent) of a sender gap and of a receiver stall.
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   wave_scoreboard board = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wave_1d_leapfrog_stencil #(
      .MAX_POINTS(MAX_POINTS_DEF)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Result side: check every accepted beat, then pick next cycle's ready.
   // Both read the pre-edge values, so the check never races the block.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check(rsp_data);
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Hold the beat until accepted, then maybe drop valid for a random gap.
   // With no gap, valid stays high and the next call simply re-asserts it.
   task automatic send_beat(input logic [MODE_W-1:0] mode, input int idx,
                            input logic signed [VALUE_W-1:0] val);
      req_type beat;
      int      gap;
      beat.mode  = mode;
      beat.index = idx[INDEX_W-1:0];
      beat.value = val;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      board.note(beat);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_q.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DAT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      board.write_csr(idx, data[CSR_DAT_W-1:0]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int tau, input int npts);
      settle();
      csr_write(CSR_TAU, tau);
      csr_write(CSR_NPTS, npts);
   endtask

   // Mix of raw 32-bit words (saturate quickly), gentle waves and the rails.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(3);
      if (r < 2) return $urandom;
      if (r == 2) return int'($urandom_range(2097152)) - 1048576;
      return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
   endfunction

   // Load every in-range point whose current or previous word is still unwritten,
   // so no advance or read ever touches an unwritten entry.
   task automatic top_up();
      for (int i = 0; i < board.points(); i++)
         if (!board.loaded(i)) send_beat(MODE_LOAD, i, pick_value());
   endtask

   task automatic random_item();
      int n, r, idx;
      n   = board.points();
      r   = $urandom_range(99);
      idx = (n < MAX_POINTS_DEF && $urandom_range(9) == 0) ?
            $urandom_range(MAX_POINTS_DEF - 1, n) : $urandom_range(n - 1);
      if (r < 30) begin
         send_beat(MODE_LOAD, idx, pick_value());
      end else if (r < 50 && board.ready_to_advance()) begin
         send_beat(MODE_ADVANCE, $urandom_range(MAX_POINTS_DEF - 1), $urandom);
      end else if (r < 94) begin
         if (idx < n && !board.readable(idx)) send_beat(MODE_LOAD, idx, pick_value());
         else send_beat(MODE_READ, idx, $urandom);
      end else begin
         send_beat(MODE_UNUSED, $urandom_range(MAX_POINTS_DEF - 1), $urandom);
      end
   endtask

   initial begin
      int tau_pick, npts_pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: three-point mesh, rails on the first two points, unity tau.
      configure(TAU_ONE, 3);
      send_beat(MODE_LOAD, 0, 32'sh7FFFFFFF);
      send_beat(MODE_LOAD, 1, 32'sh80000000);
      send_beat(MODE_LOAD, 2, 32'sh00000000);
      for (int i = 0; i < 3; i++) send_beat(MODE_READ, i, 32'sh0);
      send_beat(MODE_ADVANCE, 0, 32'sh0);                   // saturates both ways
      for (int i = 0; i < 3; i++) send_beat(MODE_READ, i, -1);
      send_beat(MODE_LOAD, 3, 32'sh00010000);               // one past the end
      send_beat(MODE_LOAD, MAX_POINTS_DEF - 1, -1);
      send_beat(MODE_READ, MAX_POINTS_DEF - 1, -1);
      send_beat(MODE_READ, 3, 32'sh0);
      send_beat(MODE_UNUSED, MAX_POINTS_DEF - 1, -1);
      send_beat(MODE_ADVANCE, MAX_POINTS_DEF - 1, -1);
      // zero tau: pure 2u - uold
      configure(0, 3);
      send_beat(MODE_ADVANCE, 0, 32'sh0);
      send_beat(MODE_READ, 1, 32'sh0);
      // tau above one is clamped
      configure(131071, 3);
      send_beat(MODE_ADVANCE, 0, 32'sh0);
      send_beat(MODE_READ, 0, 32'sh0);
      send_beat(MODE_READ, 2, 32'sh0);
      // unmapped registers are ignored; a point count below three is clamped
      settle();
      csr_write(CSR_SPARE_2, 17'h1FFFF);
      csr_write(CSR_SPARE_3, 17'h00005);
      csr_write(CSR_NPTS, 0);
      send_beat(MODE_READ, 2, 32'sh0);
      send_beat(MODE_LOAD, 2, 32'sh00010000);
      send_beat(MODE_ADVANCE, 0, 32'sh0);
      send_beat(MODE_READ, 2, 32'sh0);

      // A wider mesh once: load it all, sweep twice, read both ends.
      configure($urandom_range(TAU_ONE), WIDE_MESH);
      top_up();
      send_beat(MODE_ADVANCE, $urandom_range(MAX_POINTS_DEF - 1), $urandom);
      send_beat(MODE_ADVANCE, $urandom_range(MAX_POINTS_DEF - 1), $urandom);
      send_beat(MODE_READ, 0, 32'sh0);
      send_beat(MODE_READ, WIDE_MESH - 1, 32'sh0);
      send_beat(MODE_READ, WIDE_MESH, 32'sh0);
      repeat (10) send_beat(MODE_READ, $urandom_range(WIDE_MESH - 1), $urandom);

      // Random phases, each with its own settings and idling pattern.
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         case (ph % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 45; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 45; end
            default: begin req_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         case ($urandom_range(4))
            0: tau_pick = 0;
            1: tau_pick = TAU_ONE;
            2: tau_pick = 131071;
            3: tau_pick = $urandom_range(TAU_ONE);
            default: tau_pick = $urandom_range(131071);
         endcase
         npts_pick = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(40, 3);
         if (ph == 5) csr_write($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3, $urandom);
         configure(tau_pick, npts_pick);
         top_up();
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            random_item();
            // hold off once mid-phase until the block has drained
            if (ph == 1 && k == PHASE_ITEMS / 2) settle();
         end
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
hw/rtl/wave1d_pkg.sv
hw/rtl/wave1d_ram.sv
hw/rtl/wave1d_fifo.sv
hw/rtl/wave1d_front.sv
hw/rtl/wave1d_back.sv
hw/rtl/wave_1d_leapfrog_stencil.sv
dv/tb_wave_1d_leapfrog_stencil.sv
